// ----- rtl/dtps_pkg.sv -----
// Package: shared types, codes and helpers for the DCC throttle packet scheduler.
`timescale 1ns / 1ps

package dtps_pkg;

    // Fixed sizing of the refresh sequence and the function range
    localparam int MAX_FUNCTION = 68;
    localparam int SLOT_COUNT   = 20;

    // Item kinds
    localparam logic [3:0] KIND_SLOT      = 4'd0;
    localparam logic [3:0] KIND_SPEED_SET = 4'd1;
    localparam logic [3:0] KIND_FUNC_SET  = 4'd2;
    localparam logic [3:0] KIND_READ      = 4'd3;
    localparam logic [3:0] KIND_WRITE     = 4'd4;
    localparam logic [3:0] KIND_BIT_WRITE = 4'd5;
    localparam logic [3:0] KIND_POM_REPLY = 4'd6;
    localparam logic [3:0] KIND_SPEED_REP = 4'd7;
    localparam logic [3:0] KIND_ADDR_SET  = 4'd8;

    // Packet kinds
    localparam logic [2:0] PKT_SPEED     = 3'd0;
    localparam logic [2:0] PKT_FUNC      = 3'd1;
    localparam logic [2:0] PKT_READ      = 3'd2;
    localparam logic [2:0] PKT_WRITE     = 3'd3;
    localparam logic [2:0] PKT_BIT_WRITE = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_READ_REPEATS      = 2'd0;
    localparam logic [1:0] REG_WRITE_REPEATS     = 2'd1;
    localparam logic [1:0] REG_BIT_WRITE_REPEATS = 2'd2;

    localparam logic [7:0] REPEATS_RESET = 8'd4;
    localparam logic [7:0] OP_FAIL_VALUE = 8'h00;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

    typedef struct packed {
        logic [3:0] kind;
        logic [6:0] function_number;
        logic [7:0] reply_value;
    } item_t;

    typedef struct packed {
        logic       packet_valid;
        logic [2:0] packet_kind;
        logic [3:0] function_group;
        logic       op_done;
        logic       op_ok;
        logic [7:0] op_value;
        logic [7:0] loco_speed;
        logic       speed_changed;
    } result_t;

    typedef struct packed {
        logic [7:0] read_repeats;
        logic [7:0] write_repeats;
        logic [7:0] bit_write_repeats;
    } cfg_t;

    // F0-F4 group 0, F5-F8 group 1, F9-F12 group 2, F13-F20 group 3,
    // then eight functions per group.
    function automatic logic [3:0] group_of(input logic [6:0] num);
        logic [6:0] off;
        off = num - 7'd21;
        if (num <= 7'd4) return 4'd0;
        if (num <= 7'd8) return 4'd1;
        if (num <= 7'd12) return 4'd2;
        if (num <= 7'd20) return 4'd3;
        return 4'd4 + off[6:3];
    endfunction

endpackage

// ----- rtl/dtps_regs.sv -----
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module dtps_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output dtps_pkg::cfg_t     cfg
);
    import dtps_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_repeats      <= REPEATS_RESET;
            cfg_reg.write_repeats     <= REPEATS_RESET;
            cfg_reg.bit_write_repeats <= REPEATS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_READ_REPEATS:      cfg_reg.read_repeats      <= pwdata[7:0];
                REG_WRITE_REPEATS:     cfg_reg.write_repeats     <= pwdata[7:0];
                REG_BIT_WRITE_REPEATS: cfg_reg.bit_write_repeats <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_READ_REPEATS:      prdata = {24'd0, cfg_reg.read_repeats};
            REG_WRITE_REPEATS:     prdata = {24'd0, cfg_reg.write_repeats};
            REG_BIT_WRITE_REPEATS: prdata = {24'd0, cfg_reg.bit_write_repeats};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/dtps_core.sv -----
// Scheduler state and the single-pass decision logic for one item.
`timescale 1ns / 1ps

module dtps_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  dtps_pkg::item_t    item,
    input  dtps_pkg::cfg_t     cfg,
    output dtps_pkg::result_t  result_next
);
    import dtps_pkg::*;

    logic [4:0] slot_reg,      slot_next;
    logic [7:0] read_left_reg, read_left_next;
    logic [7:0] write_left_reg, write_left_next;
    logic [7:0] bit_left_reg,  bit_left_next;
    logic       done_reg,      done_next;
    logic       ok_reg,        ok_next;
    logic [7:0] value_reg,     value_next;
    logic [7:0] speed_reg,     speed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            read_left_reg  <= '0;
            write_left_reg <= '0;
            bit_left_reg   <= '0;
            done_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            value_reg      <= '0;
            speed_reg      <= '0;
        end
        else if (advance)
        begin
            slot_reg       <= slot_next;
            read_left_reg  <= read_left_next;
            write_left_reg <= write_left_next;
            bit_left_reg   <= bit_left_next;
            done_reg       <= done_next;
            ok_reg         <= ok_next;
            value_reg      <= value_next;
            speed_reg      <= speed_next;
        end
    end

    always_comb
    begin
        logic [7:0] read_dec;
        logic [5:0] slot_inc;
        logic [3:0] fgroup;
        logic [4:0] fslot;
        logic       served;

        read_dec = read_left_reg - 8'd1;
        slot_inc = {1'b0, slot_reg} + 6'd1;
        fgroup   = group_of(item.function_number);
        fslot    = {fgroup, 1'b1};
        served   = 1'b0;

        slot_next       = slot_reg;
        read_left_next  = read_left_reg;
        write_left_next = write_left_reg;
        bit_left_next   = bit_left_reg;
        done_next       = done_reg;
        ok_next         = ok_reg;
        value_next      = value_reg;
        speed_next      = speed_reg;
        result_next     = '0;

        unique case (item.kind)
            KIND_SLOT:
            begin
                result_next.packet_valid = 1'b1;
                // Pending read first; an expired read fails and falls through
                if (read_left_reg != 8'd0)
                begin
                    read_left_next = read_dec;
                    if (read_dec == 8'd0)
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b0;
                        value_next = OP_FAIL_VALUE;
                    end
                    else
                    begin
                        result_next.packet_kind = PKT_READ;
                        served = 1'b1;
                    end
                end
                if (!served && write_left_reg != 8'd0)
                begin
                    write_left_next = write_left_reg - 8'd1;
                    result_next.packet_kind = PKT_WRITE;
                    served = 1'b1;
                end
                if (!served && bit_left_reg != 8'd0)
                begin
                    bit_left_next = bit_left_reg - 8'd1;
                    result_next.packet_kind = PKT_BIT_WRITE;
                    served = 1'b1;
                end
                if (!served)
                begin
                    slot_next = (slot_inc >= 6'(SLOT_COUNT)) ? 5'd0 : slot_inc[4:0];
                    if (slot_reg[0])
                    begin
                        result_next.packet_kind    = PKT_FUNC;
                        result_next.function_group = slot_reg[4:1];
                    end
                    else
                    begin
                        result_next.packet_kind = PKT_SPEED;
                    end
                end
            end
            KIND_SPEED_SET:
            begin
                slot_next = {slot_reg[4:1], 1'b0};
            end
            KIND_FUNC_SET:
            begin
                if (item.function_number <= 7'(MAX_FUNCTION) &&
                    {1'b0, fslot} < 6'(SLOT_COUNT))
                begin
                    slot_next = fslot;
                end
            end
            KIND_READ:
            begin
                done_next      = 1'b0;
                ok_next        = 1'b0;
                read_left_next = (cfg.read_repeats == COUNT_MAX) ? COUNT_MAX
                                                                 : cfg.read_repeats + 8'd1;
            end
            KIND_WRITE:
            begin
                done_next       = 1'b0;
                ok_next         = 1'b0;
                write_left_next = cfg.write_repeats;
            end
            KIND_BIT_WRITE:
            begin
                done_next     = 1'b0;
                ok_next       = 1'b0;
                bit_left_next = cfg.bit_write_repeats;
            end
            KIND_POM_REPLY:
            begin
                if (read_left_reg != 8'd0 || write_left_reg != 8'd0 ||
                    bit_left_reg != 8'd0)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    value_next = item.reply_value;
                end
                if (read_left_reg != 8'd0)
                begin
                    read_left_next = 8'd0;
                end
                else if (write_left_reg != 8'd0)
                begin
                    write_left_next = 8'd0;
                end
                else if (bit_left_reg != 8'd0)
                begin
                    bit_left_next = 8'd0;
                end
            end
            KIND_SPEED_REP:
            begin
                if (item.reply_value != speed_reg)
                begin
                    speed_next = item.reply_value;
                    result_next.speed_changed = 1'b1;
                end
            end
            KIND_ADDR_SET:
            begin
                slot_next = 5'd0;
            end
            default: ;
        endcase

        result_next.op_done    = done_next;
        result_next.op_ok      = ok_next;
        result_next.op_value   = value_next;
        result_next.loco_speed = speed_next;
    end

endmodule

// ----- rtl/dcc_throttle_packet_scheduler.sv -----
// Top level of the DCC throttle packet scheduler: input stage, decision core, result stage.
`timescale 1ns / 1ps
// Path: an item transfer loads the input register, then its result loads the result
//   register; the state moves at the edge that loads the result.
// Throughput: one item per cycle, sustained, with the output side not stalling.
// Reset: rst_n clears both valid flags and all scheduler state, and loads the
//   three repeat registers with 4; no clearing pass is needed.

module dcc_throttle_packet_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    // Item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  dtps_pkg::item_t    item,
    // Result channel
    output logic               result_valid,
    input  logic               result_stall,
    output dtps_pkg::result_t  result,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import dtps_pkg::*;

    // Input stage: holds one item until the core can take it.
    logic    in_valid_reg;
    item_t   in_item_reg;
    // Result stage: holds the finished result until its transfer.
    logic    out_valid_reg;
    result_t out_result_reg;

    logic    advance;
    logic    item_take;
    cfg_t    cfg;
    result_t result_next;

    // Advance the core when an item waits and the result register is free or
    // being emptied this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    // Stall the item side only while the input register holds an item that
    // cannot advance.
    assign item_stall = in_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take || advance)
            begin
                in_valid_reg <= item_take;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset, loaded only on a transfer or advance.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    dtps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtps_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (in_item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

endmodule

// ----- rtl/dtps_checker.sv -----
// Port-level checker for the DCC throttle packet scheduler, with its bind.
`timescale 1ns / 1ps

module dtps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input dtps_pkg::result_t  result
);
    import dtps_pkg::*;

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Non-packet results carry speed kind and group zero
    a_no_packet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.packet_valid |->
            result.packet_kind == PKT_SPEED && result.function_group == 4'd0)
        else $error("packet fields set on a non-packet result");

    // A group index only comes with a function group packet
    a_group_only_func: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.function_group != 4'd0 |->
            result.packet_valid && result.packet_kind == PKT_FUNC)
        else $error("function group on a non-function packet");

    // Success implies the operation finished
    a_ok_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.op_ok |-> result.op_done)
        else $error("op_ok without op_done");

    // An empty pipeline never stalls the item side
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && !$past(item_valid) |-> !item_stall)
        else $error("item stall with nothing in flight");

endmodule

bind dcc_throttle_packet_scheduler dtps_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for the DCC throttle packet scheduler: directed and random transfers.
`timescale 1ns / 1ps

module tb_top;

    import dtps_pkg::*;

    // Kinds above the address set carry no meaning; the block must leave its state alone.
    localparam logic [3:0] KIND_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] KIND_LAST_UNUSED  = 4'd15;

    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 250;
    // Longest legal quiet spell is the receiver hold-off; the limit stays above it.
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int PRESSURE_PHASE = 3;

    // Scoreboard: keeps its own copy of the scheduler state and the repeat registers,
    // works out the packet choice for every item transfer and checks results in order.
    class packet_choice_board;
        result_t    expected_choices[$];
        int         fail_count;
        logic [7:0] read_repeats;
        logic [7:0] write_repeats;
        logic [7:0] bit_write_repeats;
        logic [4:0] refresh_slot;
        logic [7:0] read_left;
        logic [7:0] write_left;
        logic [7:0] bit_write_left;
        logic       op_finished;
        logic       op_success;
        logic [7:0] op_result;
        logic [7:0] reported_speed;

        function new();
            fail_count        = 0;
            read_repeats      = REPEATS_RESET;
            write_repeats     = REPEATS_RESET;
            bit_write_repeats = REPEATS_RESET;
            refresh_slot      = '0;
            read_left         = '0;
            write_left        = '0;
            bit_write_left    = '0;
            op_finished       = 1'b0;
            op_success        = 1'b0;
            op_result         = '0;
            reported_speed    = '0;
        endfunction

        function int pending();
            return expected_choices.size();
        endfunction

        function void set_repeats(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_READ_REPEATS:      read_repeats      = val;
                REG_WRITE_REPEATS:     write_repeats     = val;
                REG_BIT_WRITE_REPEATS: bit_write_repeats = val;
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, int got, int want);
            fail_count++;
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        endtask

        // Advance the state by one item and return the result it should produce.
        function result_t predict_choice(item_t it);
            result_t r;
            bit      served;
            int      cur;
            int      nxt;
            int      fnum;
            int      grp;
            r      = '0;
            served = 1'b0;
            case (it.kind)
                KIND_SLOT: begin
                    r.packet_valid = 1'b1;
                    // Read runs first; its last count ends it as failed and frees the slot.
                    if (read_left != 0) begin
                        read_left--;
                        if (read_left == 0) begin
                            op_finished = 1'b1;
                            op_success  = 1'b0;
                            op_result   = OP_FAIL_VALUE;
                        end else begin
                            r.packet_kind = PKT_READ;
                            served        = 1'b1;
                        end
                    end
                    if (!served && write_left != 0) begin
                        write_left--;
                        r.packet_kind = PKT_WRITE;
                        served        = 1'b1;
                    end
                    if (!served && bit_write_left != 0) begin
                        bit_write_left--;
                        r.packet_kind = PKT_BIT_WRITE;
                        served        = 1'b1;
                    end
                    if (!served) begin
                        cur = refresh_slot;
                        nxt = (cur + 1 >= SLOT_COUNT) ? 0 : cur + 1;
                        refresh_slot = nxt[4:0];
                        if (cur % 2 == 0) begin
                            r.packet_kind = PKT_SPEED;
                        end else begin
                            r.packet_kind    = PKT_FUNC;
                            r.function_group = 4'((cur - 1) / 2);
                        end
                    end
                end
                KIND_SPEED_SET: refresh_slot[0] = 1'b0;
                KIND_FUNC_SET: begin
                    fnum = it.function_number;
                    if (fnum <= MAX_FUNCTION) begin
                        if (fnum <= 4)       grp = 0;
                        else if (fnum <= 8)  grp = 1;
                        else if (fnum <= 12) grp = 2;
                        else if (fnum <= 20) grp = 3;
                        else                 grp = 4 + (fnum - 21) / 8;
                        if (2 * grp + 1 < SLOT_COUNT)
                            refresh_slot = 5'(2 * grp + 1);
                    end
                end
                KIND_READ: begin
                    op_finished = 1'b0;
                    op_success  = 1'b0;
                    read_left   = (read_repeats == COUNT_MAX) ? COUNT_MAX : read_repeats + 8'd1;
                end
                KIND_WRITE: begin
                    op_finished = 1'b0;
                    op_success  = 1'b0;
                    write_left  = write_repeats;
                end
                KIND_BIT_WRITE: begin
                    op_finished    = 1'b0;
                    op_success     = 1'b0;
                    bit_write_left = bit_write_repeats;
                end
                KIND_POM_REPLY: begin
                    // The reply closes whichever operation is served first; none pending: drop it.
                    if (read_left != 0 || write_left != 0 || bit_write_left != 0) begin
                        op_finished = 1'b1;
                        op_success  = 1'b1;
                        op_result   = it.reply_value;
                        if (read_left != 0)       read_left      = '0;
                        else if (write_left != 0) write_left     = '0;
                        else                      bit_write_left = '0;
                    end
                end
                KIND_SPEED_REP: begin
                    if (it.reply_value != reported_speed) begin
                        reported_speed  = it.reply_value;
                        r.speed_changed = 1'b1;
                    end
                end
                KIND_ADDR_SET: refresh_slot = '0;
                default: ;
            endcase
            r.op_done    = op_finished;
            r.op_ok      = op_success;
            r.op_value   = op_result;
            r.loco_speed = reported_speed;
            return r;
        endfunction

        function void note_item(item_t it);
            expected_choices.push_back(predict_choice(it));
        endfunction

        task check_choice(result_t got);
            result_t want;
            if (expected_choices.size() == 0) begin
                report_mismatch("result with nothing expected", 1, 0);
                return;
            end
            want = expected_choices.pop_front();
            if (got.packet_valid !== want.packet_valid)
                report_mismatch("packet_valid", got.packet_valid, want.packet_valid);
            if (got.packet_kind !== want.packet_kind)
                report_mismatch("packet_kind", got.packet_kind, want.packet_kind);
            if (got.function_group !== want.function_group)
                report_mismatch("function_group", got.function_group, want.function_group);
            if (got.op_done !== want.op_done)
                report_mismatch("op_done", got.op_done, want.op_done);
            if (got.op_ok !== want.op_ok)
                report_mismatch("op_ok", got.op_ok, want.op_ok);
            if (got.op_value !== want.op_value)
                report_mismatch("op_value", got.op_value, want.op_value);
            if (got.loco_speed !== want.loco_speed)
                report_mismatch("loco_speed", got.loco_speed, want.loco_speed);
            if (got.speed_changed !== want.speed_changed)
                report_mismatch("speed_changed", got.speed_changed, want.speed_changed);
        endtask
    endclass

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item_data    = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result_data;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shared control between the stimulus and the receiver side
    logic        no_idle  = 1'b0;
    logic        hold_on  = 1'b0;
    int          phase_no = 0;

    packet_choice_board board = new();

    dcc_throttle_packet_scheduler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: check every result transfer, then pick the stall for the next cycle.
    // Values read here are the ones that were stable before the edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid && !result_stall)
                board.check_choice(result_data);
            result_stall <= hold_on || (!no_idle && $urandom_range(99) < 8);
        end
    end

    // Long receiver hold-off in the no-idle phase: the sender keeps offering transfers,
    // so both pipeline stages fill and the block has to stall its input.
    initial
    begin : receiver_hold
        wait (phase_no == PRESSURE_PHASE);
        repeat (40) @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Watchdog: end the run when nothing moves on any port for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                    || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic item_t make_item(logic [3:0] kind, logic [6:0] fnum, logic [7:0] val);
        item_t it;
        it.kind            = kind;
        it.function_number = fnum;
        it.reply_value     = val;
        return it;
    endfunction

    // Mostly slots and well-formed operations; out-of-range functions, stray
    // replies and unused kinds make up the noise.
    function automatic item_t random_item();
        item_t it;
        int    roll;
        roll               = $urandom_range(99);
        it.function_number = 7'($urandom_range(127));
        it.reply_value     = 8'($urandom_range(255));
        if (roll < 45)      it.kind = KIND_SLOT;
        else if (roll < 50) it.kind = KIND_SPEED_SET;
        else if (roll < 60) begin
            it.kind = KIND_FUNC_SET;
            if ($urandom_range(99) < 85)
                it.function_number = 7'($urandom_range(MAX_FUNCTION));
        end
        else if (roll < 66) it.kind = KIND_READ;
        else if (roll < 71) it.kind = KIND_WRITE;
        else if (roll < 76) it.kind = KIND_BIT_WRITE;
        else if (roll < 85) it.kind = KIND_POM_REPLY;
        else if (roll < 92) begin
            it.kind = KIND_SPEED_REP;
            // A small value set makes repeated reports, which must not flag a change.
            if ($urandom_range(1) == 0)
                it.reply_value = 8'($urandom_range(3));
        end
        else if (roll < 95) it.kind = KIND_ADDR_SET;
        else                it.kind = 4'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
        return it;
    endfunction

    // Offer one item, idling first at random; hold the payload until the transfer.
    task automatic send_item(input item_t it);
        while (!no_idle && $urandom_range(99) < 8) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.note_item(it);
    endtask

    // Drain all expected results, then leave the pipeline idle as a margin.
    task automatic drain_results();
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one repeat register, then read it back over the same port.
    task automatic write_repeats_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_repeats(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== val)
            board.report_mismatch("register readback", prdata[7:0], val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0] rd_rep;
        logic [7:0] wr_rep;
        logic [7:0] bw_rep;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset repeats: refresh order, function extremes,
        // stray reply, each operation, read timeout, address restart, unused kind.
        send_item(make_item(KIND_SPEED_REP, 7'd0, 8'd0));
        send_item(make_item(KIND_SLOT, 7'd127, 8'd255));
        send_item(make_item(KIND_SLOT, 7'd0, 8'd0));
        send_item(make_item(KIND_SPEED_SET, 7'd0, 8'd0));
        send_item(make_item(KIND_SLOT, 7'd0, 8'd0));
        send_item(make_item(KIND_FUNC_SET, 7'd68, 8'd0));
        send_item(make_item(KIND_SLOT, 7'd0, 8'd0));
        send_item(make_item(KIND_FUNC_SET, 7'd127, 8'd0));
        send_item(make_item(KIND_SLOT, 7'd0, 8'd0));
        send_item(make_item(KIND_FUNC_SET, 7'd0, 8'd0));
        send_item(make_item(KIND_POM_REPLY, 7'd0, 8'hAA));
        send_item(make_item(KIND_READ, 7'd0, 8'd0));
        send_item(make_item(KIND_SLOT, 7'd0, 8'd0));
        send_item(make_item(KIND_POM_REPLY, 7'd0, 8'h5A));
        send_item(make_item(KIND_WRITE, 7'd0, 8'd0));
        send_item(make_item(KIND_BIT_WRITE, 7'd0, 8'd0));
        send_item(make_item(KIND_SLOT, 7'd0, 8'd0));
        send_item(make_item(KIND_POM_REPLY, 7'd0, 8'hFF));
        send_item(make_item(KIND_READ, 7'd0, 8'd0));
        repeat (6) send_item(make_item(KIND_SLOT, 7'd0, 8'd0));
        send_item(make_item(KIND_ADDR_SET, 7'd0, 8'd0));
        send_item(make_item(KIND_LAST_UNUSED, 7'd127, 8'd255));
        send_item(make_item(KIND_SPEED_REP, 7'd0, 8'd255));
        send_item(make_item(KIND_SPEED_REP, 7'd0, 8'd255));
        send_item(make_item(KIND_SPEED_REP, 7'd0, 8'd0));

        // Random phases, each under its own repeat setting: minimum, maximum with
        // read saturation, a mixed one with no idling and the hold-off, all zero,
        // then small random counts so operations complete often.
        for (int p = 1; p <= PHASES; p++) begin
            drain_results();
            case (p)
                1: begin rd_rep = 8'd1;   wr_rep = 8'd1;   bw_rep = 8'd1;   end
                2: begin rd_rep = 8'd255; wr_rep = 8'd255; bw_rep = 8'd255; end
                3: begin rd_rep = 8'd254; wr_rep = 8'd255; bw_rep = 8'd1;   end
                4: begin rd_rep = 8'd0;   wr_rep = 8'd0;   bw_rep = 8'd0;   end
                default: begin
                    rd_rep = 8'($urandom_range(1, 12));
                    wr_rep = 8'($urandom_range(1, 12));
                    bw_rep = 8'($urandom_range(1, 12));
                end
            endcase
            write_repeats_reg(REG_READ_REPEATS, rd_rep);
            write_repeats_reg(REG_WRITE_REPEATS, wr_rep);
            write_repeats_reg(REG_BIT_WRITE_REPEATS, bw_rep);
            no_idle  <= (p == PRESSURE_PHASE);
            phase_no <= p;
            repeat (PHASE_ITEMS)
                send_item(random_item());
        end

        drain_results();
        if (board.fail_count == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- dcc_throttle_packet_scheduler.f -----
rtl/dtps_pkg.sv
rtl/dtps_regs.sv
rtl/dtps_core.sv
rtl/dcc_throttle_packet_scheduler.sv
rtl/dtps_checker.sv
bench/tb_top.sv
